// ----- src/alu16_pkg.sv -----
// Shared types, constants and the division step function of the 16-bit ALU.
package alu16_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned FlagW = 3;
	localparam int unsigned DivStepsPerStage = 4;
	localparam int unsigned InTdataW = 40;
	localparam int unsigned OutTdataW = 24;

	localparam int unsigned FlagNeg = 0;
	localparam int unsigned FlagZero = 1;
	localparam int unsigned FlagOvf = 2;

	typedef enum logic [3:0] {
		FN_AND  = 4'd0,
		FN_OR   = 4'd1,
		FN_NOT  = 4'd2,
		FN_PASSB = 4'd3,
		FN_ADD  = 4'd4,
		FN_SUB  = 4'd5,
		FN_MUL  = 4'd6,
		FN_DIV  = 4'd7,
		FN_LSL  = 4'd8,
		FN_LSR  = 4'd9,
		FN_ROL  = 4'd10,
		FN_ROR  = 4'd11,
		FN_NOOP = 4'd12
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [WordW-1:0]   divisor;
		logic [WordW-1:0]   res;
		logic               ovf;
		logic [WordW-1:0]   rem;
		logic [WordW-1:0]   quo;
	} beat_t;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	function automatic beat_t div_step(input beat_t b_in);
		beat_t            b_out;
		logic [WordW:0]   trial;
		logic             fits;
		b_out = b_in;
		trial = {b_in.rem, b_in.quo[WordW-1]};
		fits = (trial >= {1'b0, b_in.divisor});
		if (fits) begin
			trial = trial - {1'b0, b_in.divisor};
		end
		b_out.rem = trial[WordW-1:0];
		b_out.quo = {b_in.quo[WordW-2:0], fits};
		return b_out;
	endfunction

endpackage

// ----- src/alu16_exec.sv -----
// Operation decode: logic, add, subtract, multiply, shifts, rotates and divider setup.
module alu16_exec (
	input  alu16_pkg::func_t              func,
	input  logic [alu16_pkg::WordW-1:0]   operand_a,
	input  logic [alu16_pkg::WordW-1:0]   operand_b,
	output alu16_pkg::beat_t              beat
);
	import alu16_pkg::*;

	logic [WordW:0]     sum;
	logic [2*WordW-1:0] product;
	logic [2*WordW-1:0] rot_l;
	logic [2*WordW-1:0] rot_r;
	logic               long_shift;
	logic [3:0]         amount;

	assign sum = {1'b0, operand_a} + {1'b0, operand_b};
	assign product = operand_a * operand_b;
	assign amount = operand_b[3:0];
	assign long_shift = (operand_b[WordW-1:4] != '0);
	assign rot_l = {operand_a, operand_a} << amount;
	assign rot_r = {operand_a, operand_a} >> amount;

	always_comb begin
		beat.func = func;
		beat.divisor = operand_b;
		beat.rem = '0;
		beat.quo = operand_a;
		beat.ovf = 1'b0;
		beat.res = '0;
		unique case (func)
			FN_AND: beat.res = operand_a & operand_b;
			FN_OR: beat.res = operand_a | operand_b;
			FN_NOT: beat.res = ~operand_b;
			FN_PASSB: beat.res = operand_b;
			FN_ADD: begin
				beat.res = sum[WordW-1:0];
				beat.ovf = sum[WordW];
			end
			FN_SUB: beat.res = operand_a - operand_b;
			FN_MUL: beat.res = product[WordW-1:0];
			FN_LSL: beat.res = long_shift ? '0 : (operand_a << amount);
			FN_LSR: beat.res = long_shift ? '0 : (operand_a >> amount);
			FN_ROL: beat.res = rot_l[2*WordW-1:WordW];
			FN_ROR: beat.res = rot_r[WordW-1:0];
			default: beat.res = '0;
		endcase
	end

endmodule

// ----- src/alu16_div_step.sv -----
// A group of restoring division steps, combinational, feeding one pipeline register.
module alu16_div_step (
	input  alu16_pkg::beat_t beat_in,
	output alu16_pkg::beat_t beat_out
);
	import alu16_pkg::*;

	always_comb begin
		beat_out = beat_in;
		for (int i = 0; i < DivStepsPerStage; i++) begin
			beat_out = div_step(beat_out);
		end
	end

endmodule

// ----- src/alu16_finish.sv -----
// Final result selection and status flag generation.
module alu16_finish (
	input  alu16_pkg::beat_t              beat,
	output logic [alu16_pkg::WordW-1:0]   result_word,
	output logic [alu16_pkg::FlagW-1:0]   status_flags
);
	import alu16_pkg::*;

	logic is_noop;

	assign is_noop = (beat.func >= FN_NOOP);

	always_comb begin
		if (beat.func == FN_DIV) begin
			result_word = (beat.divisor == '0) ? '0 : beat.quo;
		end else begin
			result_word = beat.res;
		end
		status_flags = '0;
		status_flags[FlagNeg] = result_word[WordW-1];
		status_flags[FlagZero] = (result_word == '0) && !is_noop;
		status_flags[FlagOvf] = beat.ovf;
	end

endmodule

// ----- src/alu_16bit_with_flags.sv -----
// Top level of the pipelined 16-bit ALU with status flags.
// An accepted input beat passes the stage one to four registers before its result is on m_tdata.
// Throughput is one beat per cycle while m_tready is high; the depth is set by the 16-step divider,
// four restoring steps in each of the four stages.
// Each stage moves on when the next one is empty or moving, so bubbles fill up under stall.
// Reset clears the stage valid bits only; the payload registers are not reset.
module alu_16bit_with_flags (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: func[3:0], operand_a[15:0], operand_b[15:0], zero padding.
	input  logic [alu16_pkg::InTdataW-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: result_word[15:0], status_flags[2:0], zero padding.
	output logic [alu16_pkg::OutTdataW-1:0]     m_tdata
);
	import alu16_pkg::*;

	beat_t            exec_beat;
	beat_t            div0_beat;
	beat_t            div1_beat;
	beat_t            div2_beat;
	beat_t            div3_beat;
	beat_t            beat_s1;
	beat_t            beat_s2;
	beat_t            beat_s3;
	logic [WordW-1:0] fin_result;
	logic [FlagW-1:0] fin_flags;
	logic [WordW-1:0] result_s4;
	logic [FlagW-1:0] flags_s4;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             valid_s4;
	logic             rdy1;
	logic             rdy2;
	logic             rdy3;
	logic             rdy4;

	assign rdy4 = !valid_s4 || m_tready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	alu16_exec u_exec (
		.func      (func_t'(s_tdata[3:0])),
		.operand_a (s_tdata[19:4]),
		.operand_b (s_tdata[35:20]),
		.beat      (exec_beat)
	);

	alu16_div_step u_div0 (.beat_in(exec_beat), .beat_out(div0_beat));
	alu16_div_step u_div1 (.beat_in(beat_s1), .beat_out(div1_beat));
	alu16_div_step u_div2 (.beat_in(beat_s2), .beat_out(div2_beat));
	alu16_div_step u_div3 (.beat_in(beat_s3), .beat_out(div3_beat));

	alu16_finish u_finish (
		.beat         (div3_beat),
		.result_word  (fin_result),
		.status_flags (fin_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) beat_s1 <= div0_beat;
		if (rdy2 && valid_s1) beat_s2 <= div1_beat;
		if (rdy3 && valid_s2) beat_s3 <= div2_beat;
		if (rdy4 && valid_s3) begin
			result_s4 <= fin_result;
			flags_s4 <= fin_flags;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata = {{(OutTdataW-WordW-FlagW){1'b0}}, flags_s4, result_s4};

	// An empty first stage never holds off the input.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with an empty first stage");

	// A stage that cannot hand on its beat keeps it.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rdy3) |=> valid_s2)
		else $error("stalled beat dropped from stage two");

	// The zero flag is never set together with a nonzero result.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[16+FlagZero] && (m_tdata[15:0] != 16'd0)))
		else $error("zero flag set on a nonzero result");

endmodule
